FILE: design/char_lcd_number_formatter_assert.svh
// Assertion macros used by the formatter datapath.
// Simulation builds get concurrent assertions; synthesis builds get nothing.
`ifndef CHAR_LCD_NUMBER_FORMATTER_ASSERT_SVH
`define CHAR_LCD_NUMBER_FORMATTER_ASSERT_SVH

`ifndef SYNTHESIS
// Clocked assertion that is switched off while reset is held.
`define CLNF_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("char_lcd_number_formatter assertion failed");
// Clocked assertion that also holds across reset.
`define CLNF_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("char_lcd_number_formatter reset assertion failed");
`else
`define CLNF_ASSERT(label, clk, rst_n, prop)
`define CLNF_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

FILE: design/clnf_pkg.sv
package clnf_pkg;

    // Widths of the value and of the digit string.
    localparam int MAX_DIGITS    = 16;
    localparam int VALUE_BITS    = 16;
    localparam int IN_VALUE_BITS = 16;

    // Decimal digits needed for an unsigned VALUE_BITS number (log10(2) ~ 0.30103).
    localparam int DEC_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;

    localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int DIG_N  = 2 ** IDX_W;
    localparam int CONV_W = $clog2(VALUE_BITS + 1);

    // Display formats.
    typedef enum logic [1:0] {
        OP_UDEC = 2'd0,
        OP_SDEC = 2'd1,
        OP_HEX  = 2'd2,
        OP_BIN  = 2'd3
    } t_op;

    // Lines that get a set-cursor command.
    localparam logic [1:0] LINE_1 = 2'd1;
    localparam logic [1:0] LINE_2 = 2'd2;

    // Bus bytes.
    localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
    localparam logic [7:0] LINE2_OFFSET  = 8'h40;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_A          = 8'h41;
    localparam logic [7:0] CH_PLUS       = 8'h2B;
    localparam logic [7:0] CH_MINUS      = 8'h2D;

    // Register-select codes.
    localparam logic RS_COMMAND = 1'b0;
    localparam logic RS_DATA    = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_CMD,
        ST_SIGN,
        ST_DIGIT
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic conv_step;
        logic emit_cmd;
        logic emit_sign;
        logic emit_digit;
    } t_ctrl_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic out_free;
        logic conv_done;
        logic is_decimal;
        logic need_cmd;
        logic is_signed;
        logic remain_zero;
        logic remain_one;
    } t_dp_status;

endpackage

FILE: design/clnf_ctrl.sv
module clnf_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  clnf_pkg::t_dp_status i_status,
    output clnf_pkg::t_ctrl_cmd  o_cmd
);
    import clnf_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Where the request goes once its digits are ready.
    t_state route_state;
    always_comb begin
        priority if (i_status.need_cmd) begin
            route_state = ST_CMD;
        end else if (i_status.is_signed) begin
            route_state = ST_SIGN;
        end else if (!i_status.remain_zero) begin
            route_state = ST_DIGIT;
        end else begin
            route_state = ST_IDLE;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                if (!i_status.is_decimal || i_status.conv_done) begin
                    n_state = route_state;
                end
            end
            ST_CMD: begin
                if (i_status.out_free) begin
                    priority if (i_status.is_signed) begin
                        n_state = ST_SIGN;
                    end else if (!i_status.remain_zero) begin
                        n_state = ST_DIGIT;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_SIGN: begin
                if (i_status.out_free) begin
                    n_state = i_status.remain_zero ? ST_IDLE : ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (i_status.out_free && i_status.remain_one) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_CONV: begin
                o_cmd.conv_step = i_status.is_decimal && !i_status.conv_done;
            end
            ST_CMD: begin
                o_cmd.emit_cmd = i_status.out_free;
            end
            ST_SIGN: begin
                o_cmd.emit_sign = i_status.out_free;
            end
            ST_DIGIT: begin
                o_cmd.emit_digit = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

FILE: design/clnf_datapath.sv
`include "char_lcd_number_formatter_assert.svh"

module clnf_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  clnf_pkg::t_ctrl_cmd  i_cmd,
    output clnf_pkg::t_dp_status o_status,
    input  logic [1:0]          i_operation,
    input  logic [1:0]          i_line,
    input  logic [5:0]          i_column,
    input  logic [15:0]         i_value,
    input  logic [4:0]          i_digit_count,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_reg_select,
    output logic [7:0]          o_bus_byte,
    output logic                o_last_write
);
    import clnf_pkg::*;

    // Request registers.
    logic [1:0]              r_op;
    logic [1:0]              r_line;
    logic [5:0]              r_col;
    logic                    r_neg;
    logic [VALUE_BITS-1:0]   r_mag;
    logic [4*DEC_DIGITS-1:0] r_bcd;
    logic [CONV_W-1:0]       r_conv_cnt;
    logic [CNT_W-1:0]        r_remain;

    // Output register.
    logic       r_out_valid;
    logic       r_rs;
    logic [7:0] r_byte;
    logic       r_last;

    // Input value cut or widened to VALUE_BITS.
    logic [VALUE_BITS+IN_VALUE_BITS-1:0] in_ext;
    logic [VALUE_BITS-1:0]               in_v;
    logic                                in_neg;
    logic [CNT_W-1:0]                    in_count;

    assign in_ext = {{VALUE_BITS{1'b0}}, i_value};
    assign in_v   = in_ext[VALUE_BITS-1:0];
    assign in_neg = (t_op'(i_operation) == OP_SDEC) && in_v[VALUE_BITS-1];

    always_comb begin
        if (int'(i_digit_count) > MAX_DIGITS) begin
            in_count = CNT_W'(MAX_DIGITS);
        end else begin
            in_count = CNT_W'(i_digit_count);
        end
    end

    // One shift-add-3 step of the binary to BCD conversion.
    logic [4*DEC_DIGITS-1:0] bcd_adj;
    always_comb begin
        for (int d = 0; d < DEC_DIGITS; d++) begin
            if (r_bcd[4*d +: 4] >= 4'd5) begin
                bcd_adj[4*d +: 4] = r_bcd[4*d +: 4] + 4'd3;
            end else begin
                bcd_adj[4*d +: 4] = r_bcd[4*d +: 4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op       <= i_operation;
            r_line     <= i_line;
            r_col      <= i_column;
            r_neg      <= in_neg;
            r_mag      <= in_neg ? (~in_v + 1'b1) : in_v;
            r_bcd      <= '0;
            r_conv_cnt <= CONV_W'(VALUE_BITS);
            r_remain   <= in_count;
        end else if (i_cmd.conv_step) begin
            r_bcd      <= {bcd_adj[4*DEC_DIGITS-2:0], r_mag[VALUE_BITS-1]};
            r_mag      <= {r_mag[VALUE_BITS-2:0], 1'b0};
            r_conv_cnt <= r_conv_cnt - 1'b1;
        end else if (i_cmd.emit_digit) begin
            r_remain   <= r_remain - 1'b1;
        end
    end

    // Digit table: every position's digit for the current format.
    logic [4*DIG_N+VALUE_BITS-1:0]   mag_pad;
    logic [4*DIG_N+4*DEC_DIGITS-1:0] bcd_pad;
    logic [3:0]                      digits [DIG_N];

    assign mag_pad = {{(4*DIG_N){1'b0}}, r_mag};
    assign bcd_pad = {{(4*DIG_N){1'b0}}, r_bcd};

    always_comb begin
        for (int i = 0; i < DIG_N; i++) begin
            unique case (t_op'(r_op))
                OP_HEX:  digits[i] = mag_pad[4*i +: 4];
                OP_BIN:  digits[i] = {3'b000, mag_pad[i]};
                default: digits[i] = bcd_pad[4*i +: 4];
            endcase
        end
    end

    logic [CNT_W-1:0] remain_m1;
    logic [IDX_W-1:0] dig_idx;
    logic [3:0]       dig;
    logic [7:0]       dig_char;

    assign remain_m1 = r_remain - 1'b1;
    assign dig_idx   = remain_m1[IDX_W-1:0];
    assign dig       = digits[dig_idx];
    assign dig_char  = (dig < 4'd10) ? (CH_ZERO + {4'b0000, dig})
                                     : (CH_A + {4'b0000, dig} - 8'd10);

    // Set-cursor address is column - 1 plus the line offset, wrapping modulo 256.
    logic [7:0] cursor_addr;
    assign cursor_addr = {2'b00, r_col} + 8'hFF + ((r_line == LINE_2) ? LINE2_OFFSET : 8'h00);

    logic emit_any;
    assign emit_any = i_cmd.emit_cmd || i_cmd.emit_sign || i_cmd.emit_digit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_any) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (i_cmd.emit_cmd) begin
            r_rs   <= RS_COMMAND;
            r_byte <= CMD_SET_DDRAM | cursor_addr;
            r_last <= (t_op'(r_op) != OP_SDEC) && (r_remain == '0);
        end else if (i_cmd.emit_sign) begin
            r_rs   <= RS_DATA;
            r_byte <= r_neg ? CH_MINUS : CH_PLUS;
            r_last <= (r_remain == '0);
        end else if (i_cmd.emit_digit) begin
            r_rs   <= RS_DATA;
            r_byte <= dig_char;
            r_last <= (r_remain == CNT_W'(1));
        end
    end

    assign o_status.out_free    = !r_out_valid || i_out_ready;
    assign o_status.conv_done   = (r_conv_cnt == '0);
    assign o_status.is_decimal  = (t_op'(r_op) == OP_UDEC) || (t_op'(r_op) == OP_SDEC);
    assign o_status.need_cmd    = (r_line == LINE_1) || (r_line == LINE_2);
    assign o_status.is_signed   = (t_op'(r_op) == OP_SDEC);
    assign o_status.remain_zero = (r_remain == '0);
    assign o_status.remain_one  = (r_remain == CNT_W'(1));

    assign o_out_valid  = r_out_valid;
    assign o_reg_select = r_rs;
    assign o_bus_byte   = r_byte;
    assign o_last_write = r_last;

    `CLNF_ASSERT(a_one_emit, i_clk, i_rst_n, $onehot0({i_cmd.emit_cmd, i_cmd.emit_sign, i_cmd.emit_digit}))
    `CLNF_ASSERT(a_emit_room, i_clk, i_rst_n, emit_any |-> (!r_out_valid || i_out_ready))
    `CLNF_ASSERT(a_digit_left, i_clk, i_rst_n, i_cmd.emit_digit |-> (r_remain != '0))
    `CLNF_ASSERT(a_conv_bound, i_clk, i_rst_n, i_cmd.conv_step |-> (r_conv_cnt != '0))
    `CLNF_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !r_out_valid)

endmodule

FILE: design/char_lcd_number_formatter.sv
// Channel   Direction  Handshake                   Payload
// request   in         i_in_valid / o_in_ready     i_operation, i_line, i_column, i_value,
//                                                  i_digit_count
// bus write out        o_out_valid / i_out_ready   o_reg_select, o_bus_byte, o_last_write
//
// One request is handled at a time. A decimal request passes through the shift-add-3
// BCD converter (one bit per cycle); hex and binary skip the conversion steps. After
// that, the bus writes follow at one per cycle while the output register is free.
// Reset is synchronous and active low; it empties the output register and idles the
// controller. A stalled output only holds the write sequence; the request port opens
// again as soon as the final write has entered the output register.
module char_lcd_number_formatter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_operation,
    input  logic [1:0]  i_line,
    input  logic [5:0]  i_column,
    input  logic [15:0] i_value,
    input  logic [4:0]  i_digit_count,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_reg_select,
    output logic [7:0]  o_bus_byte,
    output logic        o_last_write
);
    import clnf_pkg::*;

    // The controller sequences the transaction: accept, convert, then the cursor command
    // and the sign where the request calls for them, and the digits. The datapath holds
    // the request, runs the BCD conversion and owns the output register.
    t_ctrl_cmd  ctrl_cmd;
    t_dp_status dp_status;

    clnf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (dp_status),
        .o_cmd      (ctrl_cmd)
    );

    clnf_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (ctrl_cmd),
        .o_status      (dp_status),
        .i_operation   (i_operation),
        .i_line        (i_line),
        .i_column      (i_column),
        .i_value       (i_value),
        .i_digit_count (i_digit_count),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_reg_select  (o_reg_select),
        .o_bus_byte    (o_bus_byte),
        .o_last_write  (o_last_write)
    );

endmodule
